/* hw/rtl/third_order_highpass_iir_unit_assert.svh */
// Assertion macros used by the filter's top-level RTL file.
// Both macros sample on the rising edge of clock and are disabled while reset is high.
`ifndef THIRD_ORDER_HIGHPASS_IIR_UNIT_ASSERT_SVH
`define THIRD_ORDER_HIGHPASS_IIR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define THPF_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define THPF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/thpf_pkg.sv */
`default_nettype none
package thpf_pkg;

   localparam int SAMPLE_W         = 24;
   localparam int CHAN_W           = 3;
   localparam int COEF_W           = 32;
   localparam int YHIST_W          = 32;
   localparam int DIFF_W           = SAMPLE_W + 1;
   localparam int PROD_W           = 2 * COEF_W;
   localparam int ACC_W            = 60;
   localparam int FB_SHIFT         = 8;
   localparam int Y_SHIFT          = 20;
   localparam int OUT_SHIFT        = 8;
   localparam int DEFAULT_CHANNELS = 8;

   localparam int NUM_REGS  = 5;
   localparam int REG_IDX_W = 3;

   localparam logic [REG_IDX_W-1:0] CSR_COEF_A0 = 3'd0;
   localparam logic [REG_IDX_W-1:0] CSR_COEF_A1 = 3'd1;
   localparam logic [REG_IDX_W-1:0] CSR_COEF_B1 = 3'd2;
   localparam logic [REG_IDX_W-1:0] CSR_COEF_B2 = 3'd3;
   localparam logic [REG_IDX_W-1:0] CSR_COEF_B3 = 3'd4;

   localparam logic ACTION_FILTER = 1'b0;
   localparam logic ACTION_CLEAR  = 1'b1;

   // Multiply-accumulate sequence: five products, the last one added in the drain step.
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_A0      = 3'd0;
   localparam logic [STEP_W-1:0] STEP_A1      = 3'd1;
   localparam logic [STEP_W-1:0] STEP_B1      = 3'd2;
   localparam logic [STEP_W-1:0] STEP_B2      = 3'd3;
   localparam logic [STEP_W-1:0] STEP_B3      = 3'd4;
   localparam logic [STEP_W-1:0] STEP_DRAIN   = 3'd5;
   // From this step on, the product being added is a feedback term.
   localparam logic [STEP_W-1:0] STEP_FB_ACC  = 3'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MAC,
      ST_SAT,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic clear;
      logic mul_en;
      logic acc_en;
      logic sub;
   } mac_ctrl_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] x1;
      logic signed [SAMPLE_W-1:0] x2;
      logic signed [SAMPLE_W-1:0] x3;
      logic signed [YHIST_W-1:0]  y1;
      logic signed [YHIST_W-1:0]  y2;
      logic signed [YHIST_W-1:0]  y3;
   } hist_type;

   localparam int HIST_W = $bits(hist_type);

endpackage
`default_nettype wire

/* hw/rtl/thpf_req_if.sv */
`default_nettype none
interface thpf_req_if;
   import thpf_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       action;
   logic signed [SAMPLE_W-1:0] sample_in;
   logic [CHAN_W-1:0]          channel_in;

   modport source (output valid, output action, output sample_in, output channel_in,
                   input ready);
   modport sink (input valid, input action, input sample_in, input channel_in,
                 output ready);
endinterface
`default_nettype wire

/* hw/rtl/thpf_rsp_if.sv */
`default_nettype none
interface thpf_rsp_if;
   import thpf_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_out;
   logic [CHAN_W-1:0]          channel_out;

   modport source (output valid, output sample_out, output channel_out, input ready);
   modport sink (input valid, input sample_out, input channel_out, output ready);
endinterface
`default_nettype wire

/* hw/rtl/thpf_ram.sv */
`default_nettype none
module thpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/thpf_mac.sv */
`default_nettype none
module thpf_mac (
   input  wire logic                               clock,
   input  wire thpf_pkg::mac_ctrl_type             ctrl,
   input  wire logic signed [thpf_pkg::COEF_W-1:0] op_a,
   input  wire logic signed [thpf_pkg::COEF_W-1:0] op_b,
   output logic signed [thpf_pkg::ACC_W-1:0]       acc
);
   import thpf_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_fb;
   logic signed [ACC_W-1:0]  term;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);
   // Feedback products carry eight extra fraction bits, floored away here.
   assign prod_fb = prod_ff >>> FB_SHIFT;

   always_comb begin
      term   = ctrl.sub ? -ACC_W'(prod_fb) : ACC_W'(prod_ff);
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (ctrl.acc_en) begin
         acc_in = acc_ff + term;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule
`default_nettype wire

/* hw/rtl/third_order_highpass_iir_unit.sv */
// Multichannel third-order IIR highpass filter. Each request beat carries a 24-bit signed
// sample and a channel number; the response beat carries
// y = a0(x - x3) + a1(x1 - x2) - b1*y1 - b2*y2 - b3*y3, rounded and saturated to 24 bits,
// with the same channel number. A request with action set clears the history of every
// channel and gives no response; a sample whose channel is not below CHANNELS is dropped
// without a response. The user must write the five Q4.28 coefficients through the csr port
// only while the block is idle; the block itself does not enforce this. A filtered sample
// passes through a history-read state that reads the channel's history from the history
// RAM, multiply-accumulate steps in which a single shared 32x32 multiplier forms the five
// products and the accumulator adds them, a rounding and saturation state, and a write-back
// state that writes the shifted history back and loads the output register. The write-back
// state is held for as long as the previous response still sits untaken in the output
// register. The next request is accepted in the cycle after that write-back, so the block
// takes one sample at a time. The response register lets a new sample be accepted while
// the previous response still waits to be taken. History is cleared by per-channel valid
// bits, so there is no clearing pass after reset.
`default_nettype none
`include "third_order_highpass_iir_unit_assert.svh"
module third_order_highpass_iir_unit #(
   parameter int CHANNELS = thpf_pkg::DEFAULT_CHANNELS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   thpf_req_if.sink                                 req_bus,
   thpf_rsp_if.source                               rsp_bus,
   input  wire logic                                csr_we,
   input  wire logic [thpf_pkg::REG_IDX_W-1:0]      csr_index,
   input  wire logic [thpf_pkg::COEF_W-1:0]         csr_wdata
);
   import thpf_pkg::*;

   localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int WIDE_W = (ADDR_W > CHAN_W) ? ADDR_W : CHAN_W;
   localparam logic signed [ACC_W-1:0] ROUND_Y = ACC_W'(1) <<< (Y_SHIFT - 1);
   localparam logic signed [YHIST_W:0] ROUND_OUT = (YHIST_W + 1)'(1) <<< (OUT_SHIFT - 1);
   localparam int SH_W  = ACC_W - Y_SHIFT;
   localparam int OUT_W = YHIST_W + 1 - OUT_SHIFT;

   // Control state.
   state_type             state_ff, state_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [CHANNELS-1:0]   valid_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [COEF_W-1:0] coef_ff [NUM_REGS];

   // Per-sample working registers.
   logic signed [SAMPLE_W-1:0] x_ff;
   logic [CHAN_W-1:0]          chan_ff;
   hist_type                   hist_ff;
   logic signed [DIFF_W-1:0]   d0_ff;
   logic signed [DIFF_W-1:0]   d1_ff;
   logic signed [YHIST_W-1:0]  yf_ff;
   logic signed [YHIST_W-1:0]  yf_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;
   logic signed [SAMPLE_W-1:0] rsp_sample_in;
   logic [CHAN_W-1:0]          rsp_chan_ff;

   // Strobes from the sequencer.
   logic         req_ready;
   logic         take_sample;
   logic         clear_hist;
   logic         ram_re;
   logic         ram_we;
   logic         rsp_load;
   mac_ctrl_type mac_ctrl;

   logic [WIDE_W-1:0] req_chan_wide;
   logic [WIDE_W-1:0] cur_chan_wide;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic              chan_ok;
   logic [HIST_W-1:0] ram_rdata;
   hist_type          rd_hist;
   hist_type          wb_hist;

   logic signed [COEF_W-1:0] op_a;
   logic signed [COEF_W-1:0] op_b;
   logic signed [ACC_W-1:0]  acc;
   logic signed [ACC_W-1:0]  acc_rnd;
   logic signed [SH_W-1:0]   acc_sh;
   logic signed [YHIST_W:0]  y_rnd;
   logic signed [OUT_W-1:0]  y_sh;

   assign req_chan_wide = WIDE_W'(req_bus.channel_in);
   assign cur_chan_wide = WIDE_W'(chan_ff);
   assign rd_addr       = req_chan_wide[ADDR_W-1:0];
   assign wr_addr       = cur_chan_wide[ADDR_W-1:0];
   assign chan_ok       = (32'(req_bus.channel_in) < 32'(CHANNELS));

   // Sequencer: idle, history read, multiply-accumulate steps, saturation, write-back.
   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      req_ready   = 1'b0;
      take_sample = 1'b0;
      clear_hist  = 1'b0;
      ram_re      = 1'b0;
      ram_we      = 1'b0;
      rsp_load    = 1'b0;
      mac_ctrl    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_bus.valid) begin
               if (req_bus.action == ACTION_CLEAR) begin
                  clear_hist = 1'b1;
               end else if (chan_ok) begin
                  take_sample = 1'b1;
                  ram_re      = 1'b1;
                  state_in    = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_MAC;
            step_in  = STEP_A0;
         end
         ST_MAC: begin
            mac_ctrl.clear  = (step_ff == STEP_A0);
            mac_ctrl.mul_en = (step_ff != STEP_DRAIN);
            mac_ctrl.acc_en = (step_ff != STEP_A0);
            mac_ctrl.sub    = (step_ff >= STEP_FB_ACC);
            if (step_ff == STEP_DRAIN) begin
               state_in = ST_SAT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_SAT: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               ram_we   = 1'b1;
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_A0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_REGS; i++) begin
            coef_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (clear_hist) begin
            valid_ff <= '0;
         end else if (ram_we) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_COEF_A0: coef_ff[CSR_COEF_A0] <= csr_wdata;
               CSR_COEF_A1: coef_ff[CSR_COEF_A1] <= csr_wdata;
               CSR_COEF_B1: coef_ff[CSR_COEF_B1] <= csr_wdata;
               CSR_COEF_B2: coef_ff[CSR_COEF_B2] <= csr_wdata;
               CSR_COEF_B3: coef_ff[CSR_COEF_B3] <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // A channel whose valid bit is clear has an all-zero history.
   always_comb begin
      rd_hist = valid_ff[wr_addr] ? hist_type'(ram_rdata) : '0;
      wb_hist.x1 = x_ff;
      wb_hist.x2 = hist_ff.x1;
      wb_hist.x3 = hist_ff.x2;
      wb_hist.y1 = yf_ff;
      wb_hist.y2 = hist_ff.y1;
      wb_hist.y3 = hist_ff.y2;
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      case (step_ff)
         STEP_A0: begin
            op_a = coef_ff[CSR_COEF_A0];
            op_b = COEF_W'(d0_ff);
         end
         STEP_A1: begin
            op_a = coef_ff[CSR_COEF_A1];
            op_b = COEF_W'(d1_ff);
         end
         STEP_B1: begin
            op_a = coef_ff[CSR_COEF_B1];
            op_b = hist_ff.y1;
         end
         STEP_B2: begin
            op_a = coef_ff[CSR_COEF_B2];
            op_b = hist_ff.y2;
         end
         STEP_B3: begin
            op_a = coef_ff[CSR_COEF_B3];
            op_b = hist_ff.y3;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // Round the Q.28 sum to eight fraction bits and saturate to 32 bits.
   always_comb begin
      acc_rnd = acc + ROUND_Y;
      acc_sh  = acc_rnd[ACC_W-1:Y_SHIFT];
      if ((&acc_sh[SH_W-1:YHIST_W-1]) || !(|acc_sh[SH_W-1:YHIST_W-1])) begin
         yf_in = acc_sh[YHIST_W-1:0];
      end else if (acc_sh[SH_W-1]) begin
         yf_in = {1'b1, {(YHIST_W-1){1'b0}}};
      end else begin
         yf_in = {1'b0, {(YHIST_W-1){1'b1}}};
      end
   end

   // Round away the extra fraction bits and saturate to the sample width.
   always_comb begin
      y_rnd = (YHIST_W + 1)'(yf_ff) + ROUND_OUT;
      y_sh  = y_rnd[YHIST_W:OUT_SHIFT];
      if (y_sh[OUT_W-1] == y_sh[SAMPLE_W-1]) begin
         rsp_sample_in = y_sh[SAMPLE_W-1:0];
      end else if (y_sh[OUT_W-1]) begin
         rsp_sample_in = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         rsp_sample_in = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (take_sample) begin
         x_ff    <= req_bus.sample_in;
         chan_ff <= req_bus.channel_in;
      end
      if (state_ff == ST_READ) begin
         hist_ff <= rd_hist;
         d0_ff   <= DIFF_W'(x_ff) - DIFF_W'(rd_hist.x3);
         d1_ff   <= DIFF_W'(rd_hist.x1) - DIFF_W'(rd_hist.x2);
      end
      if (state_ff == ST_SAT) begin
         yf_ff <= yf_in;
      end
      if (rsp_load) begin
         rsp_sample_ff <= rsp_sample_in;
         rsp_chan_ff   <= chan_ff;
      end
   end

   thpf_ram #(
      .WIDTH (HIST_W),
      .DEPTH (CHANNELS)
   ) u_hist_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (wr_addr),
      .wdata (HIST_W'(wb_hist)),
      .re    (ram_re),
      .raddr (rd_addr),
      .rdata (ram_rdata)
   );

   thpf_mac u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .op_a  (op_a),
      .op_b  (op_b),
      .acc   (acc)
   );

   assign req_bus.ready       = req_ready;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.sample_out  = rsp_sample_ff;
   assign rsp_bus.channel_out = rsp_chan_ff;

   `THPF_ASSERT_NEXT(a_clear_all, req_bus.valid && req_bus.ready && req_bus.action == ACTION_CLEAR, valid_ff == '0, "clear beat left a channel history marked valid")
   `THPF_ASSERT_SAME(a_rsp_from_fin, $rose(rsp_bus.valid), $past(state_ff) == ST_FIN, "response raised outside write-back")
   `THPF_ASSERT_NEXT(a_wb_marks_valid, ram_we, valid_ff[$past(wr_addr)], "written channel not marked valid")
   `THPF_ASSERT_NEXT(a_read_then_mac, state_ff == ST_READ, state_ff == ST_MAC && step_ff == STEP_A0, "history read not followed by first product")

endmodule
`default_nettype wire
